// ===== design/redundant_command_sequence_filter_top_defines.svh =====
// ============================================================================
// Redundant command sequence filter: assertion macros
// Shared macros for the concurrent checks of the filter's own control logic.
// ============================================================================
`ifndef REDUNDANT_COMMAND_SEQUENCE_FILTER_TOP_DEFINES_SVH
`define REDUNDANT_COMMAND_SEQUENCE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RCSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RCSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rcsf_pkg.sv =====
// ============================================================================
// Redundant command sequence filter: package
// Transaction types and codes shared by the filter and its checks.
// ============================================================================
package rcsf_pkg;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_MOVE   = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_MOVE   = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED    = 2'd0,
        ST_SERIES_MISS = 2'd1,
        ST_DUPLICATE   = 2'd2,
        ST_OUT_OF_ORDER = 2'd3
    } t_status;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         seq_num;
        logic [7:0]         series_num;
        logic [7:0]         moves_minus_one;
        logic signed [7:0]  move_direction;
        logic [7:0]         stealth;
        logic [31:0]        z_bits;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [7:0]         lost_packets;
        logic [7:0]         missing_moves;
        logic [7:0]         seq_out;
        logic signed [7:0]  move_direction_out;
        logic [7:0]         stealth_out;
        logic [31:0]        z_bits_out;
    } t_out_item;

endpackage

// ===== design/redundant_command_sequence_filter_top.sv =====
// ============================================================================
// Redundant command sequence filter
// Drops repeated and stale move records and reports sequence status.
// ============================================================================
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) carries header and
// move transactions. Each header yields one status transaction on the output
// channel (o_out_valid, i_out_stall, o_out_data); each move not delivered
// before yields one move transaction tagged with its sequence number, and
// other moves yield nothing.
// Each result is written to the output register as its input is accepted,
// and one transaction can be accepted every cycle while o_in_stall is low.
// The only storage between the two sides is the output register, so the
// input is stalled only while that register is full and the receiver stalls;
// it is taken again in the very cycle the receiver takes the waiting result.
// Reset clears the series register, the sequence history and o_out_valid,
// and arms priming so that the first matching header sets the last-seen
// number. Writing i_cfg_data with i_cfg_we sets the expected series and re-arms
// priming; the user must do so only while the filter is idle (not enforced).
`include "redundant_command_sequence_filter_top_defines.svh"

module redundant_command_sequence_filter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rcsf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rcsf_pkg::t_out_item o_out_data
);

    logic [7:0]          r_series;
    logic [7:0]          r_last_seq;
    logic                r_first_pending;
    logic                r_packet_ok;
    logic [7:0]          r_moves_left;
    logic [7:0]          r_skip_left;
    logic [7:0]          r_next_out_seq;
    logic                r_out_valid;
    rcsf_pkg::t_out_item r_out;

    logic [7:0]          n_last_seq;
    logic                n_first_pending;
    logic                n_packet_ok;
    logic [7:0]          n_moves_left;
    logic [7:0]          n_skip_left;
    logic [7:0]          n_next_out_seq;
    logic                n_has_result;
    rcsf_pkg::t_out_item n_out;

    logic                in_acc;
    logic [7:0]          count;
    logic [7:0]          base_seq;
    logic [7:0]          seq_dist;
    logic                series_hit;
    logic                covered;
    logic [7:0]          skip;
    logic                move_emit;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign count      = i_in_data.moves_minus_one + 8'd1;
    assign series_hit = (i_in_data.series_num == r_series);
    assign base_seq   = r_first_pending ? (i_in_data.seq_num - count) : r_last_seq;
    assign seq_dist   = i_in_data.seq_num - base_seq;
    assign covered    = (count >= seq_dist);
    assign skip       = covered ? (count - seq_dist) : 8'd0;
    assign move_emit  = r_packet_ok && (r_skip_left == 8'd0) && (r_moves_left != 8'd0);

    always_comb begin
        n_last_seq      = r_last_seq;
        n_first_pending = r_first_pending;
        n_packet_ok     = r_packet_ok;
        n_moves_left    = r_moves_left;
        n_skip_left     = r_skip_left;
        n_next_out_seq  = r_next_out_seq;
        n_has_result    = 1'b0;
        n_out           = '0;
        if (i_in_data.cmd == rcsf_pkg::CMD_HEADER) begin
            n_has_result   = 1'b1;
            n_out.kind     = rcsf_pkg::KIND_HEADER;
            n_packet_ok    = 1'b0;
            n_moves_left   = 8'd0;
            n_skip_left    = 8'd0;
            if (!series_hit) begin
                n_out.status = rcsf_pkg::ST_SERIES_MISS;
            end else begin
                n_first_pending = 1'b0;
                n_last_seq      = base_seq;
                if (seq_dist == 8'd0) begin
                    n_out.status = rcsf_pkg::ST_DUPLICATE;
                end else if (seq_dist[7]) begin
                    n_out.status = rcsf_pkg::ST_OUT_OF_ORDER;
                end else begin
                    n_out.status        = rcsf_pkg::ST_ACCEPTED;
                    n_out.lost_packets  = seq_dist - 8'd1;
                    n_out.missing_moves = covered ? 8'd0 : (seq_dist - count);
                    n_last_seq          = i_in_data.seq_num;
                    n_packet_ok         = 1'b1;
                    n_skip_left         = skip;
                    n_moves_left        = count - skip;
                    n_next_out_seq      = i_in_data.seq_num - count + 8'd1 + skip;
                end
            end
        end else if (r_packet_ok) begin
            if (r_skip_left != 8'd0) begin
                n_skip_left = r_skip_left - 8'd1;
            end else if (r_moves_left != 8'd0) begin
                n_has_result             = 1'b1;
                n_out.kind               = rcsf_pkg::KIND_MOVE;
                n_out.seq_out            = r_next_out_seq;
                n_out.move_direction_out = i_in_data.move_direction;
                n_out.stealth_out        = i_in_data.stealth;
                n_out.z_bits_out         = i_in_data.z_bits;
                n_next_out_seq           = r_next_out_seq + 8'd1;
                n_moves_left             = r_moves_left - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series        <= 8'd0;
            r_last_seq      <= 8'd0;
            r_first_pending <= 1'b1;
            r_packet_ok     <= 1'b0;
            r_moves_left    <= 8'd0;
            r_skip_left     <= 8'd0;
            r_next_out_seq  <= 8'd0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_last_seq      <= n_last_seq;
                r_packet_ok     <= n_packet_ok;
                r_moves_left    <= n_moves_left;
                r_skip_left     <= n_skip_left;
                r_next_out_seq  <= n_next_out_seq;
                r_out_valid     <= n_has_result;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_series        <= i_cfg_data;
                r_first_pending <= 1'b1;
            end else if (in_acc) begin
                r_first_pending <= n_first_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RCSF_ASSERT_NEXT(a_header_gives_status,
        in_acc && (i_in_data.cmd == rcsf_pkg::CMD_HEADER),
        o_out_valid && (o_out_data.kind == rcsf_pkg::KIND_HEADER),
        "Accepted header did not produce a status transaction")
    `RCSF_ASSERT_NEXT(a_skip_drops_move,
        in_acc && (i_in_data.cmd == rcsf_pkg::CMD_MOVE) && r_packet_ok
            && (r_skip_left != 8'd0),
        !o_out_valid && (r_skip_left == 8'($past(r_skip_left) - 8'd1)),
        "Skipped move was delivered or the skip count did not step")
    `RCSF_ASSERT_NEXT(a_move_tag_steps,
        in_acc && (i_in_data.cmd == rcsf_pkg::CMD_MOVE) && move_emit && !i_cfg_we,
        o_out_valid && (o_out_data.kind == rcsf_pkg::KIND_MOVE)
            && (r_next_out_seq == 8'(o_out_data.seq_out + 8'd1)),
        "Delivered move tag and next tag are out of step")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Redundant command sequence filter: testbench
// Sends header and move transactions in bursts against a receiver that stalls
// on a pattern of its own. A scoreboard class predicts every status and
// delivered move transaction and checks each output against the oldest one.
// ============================================================================
module testbench;

    localparam int IDLE_LIMIT    = 5000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASE_COUNT   = 10;

    class sequence_scoreboard;
        logic [7:0]          series;
        logic [7:0]          last_seq;
        logic [7:0]          moves_left;
        logic [7:0]          skip_left;
        logic [7:0]          next_tag;
        bit                  first_pending;
        bit                  packet_ok;
        rcsf_pkg::t_out_item due_reports[$];
        int                  mismatches;

        function new();
            series          = 8'd0;
            last_seq        = 8'd0;
            moves_left      = 8'd0;
            skip_left       = 8'd0;
            next_tag        = 8'd0;
            first_pending   = 1'b1;
            packet_ok       = 1'b0;
            mismatches      = 0;
        endfunction

        function void write_series(logic [7:0] value);
            series        = value;
            first_pending = 1'b1;
        endfunction

        function void record_item(rcsf_pkg::t_in_item it);
            rcsf_pkg::t_out_item rep;
            logic [7:0]          count;
            logic [7:0]          distance;
            logic [7:0]          skip;
            rep = '0;
            if (it.cmd == rcsf_pkg::CMD_HEADER) begin
                count      = it.moves_minus_one + 8'd1;
                packet_ok  = 1'b0;
                moves_left = 8'd0;
                skip_left  = 8'd0;
                rep.kind   = rcsf_pkg::KIND_HEADER;
                if (it.series_num != series) begin
                    rep.status = rcsf_pkg::ST_SERIES_MISS;
                end else begin
                    if (first_pending) begin
                        last_seq      = it.seq_num - count;
                        first_pending = 1'b0;
                    end
                    distance = it.seq_num - last_seq;
                    if (distance == 8'd0) begin
                        rep.status = rcsf_pkg::ST_DUPLICATE;
                    end else if (distance[7]) begin
                        rep.status = rcsf_pkg::ST_OUT_OF_ORDER;
                    end else begin
                        skip       = 8'd0;
                        rep.status = rcsf_pkg::ST_ACCEPTED;
                        if (count >= distance) begin
                            skip = count - distance;
                        end else begin
                            rep.missing_moves = distance - count;
                        end
                        rep.lost_packets = distance - 8'd1;
                        last_seq   = it.seq_num;
                        packet_ok  = 1'b1;
                        skip_left  = skip;
                        moves_left = count - skip;
                        next_tag   = it.seq_num - count + 8'd1 + skip;
                    end
                end
                due_reports.push_back(rep);
            end else if (packet_ok) begin
                if (skip_left != 8'd0) begin
                    skip_left--;
                end else if (moves_left != 8'd0) begin
                    rep.kind               = rcsf_pkg::KIND_MOVE;
                    rep.seq_out            = next_tag;
                    rep.move_direction_out = it.move_direction;
                    rep.stealth_out        = it.stealth;
                    rep.z_bits_out         = it.z_bits;
                    next_tag++;
                    moves_left--;
                    due_reports.push_back(rep);
                end
            end
        endfunction

        function string show(rcsf_pkg::t_out_item r);
            return $sformatf({"kind %0d status %0d lost %0d missing %0d seq %0d ",
                              "dir %0d stealth %0d z %h"},
                             r.kind, r.status, r.lost_packets, r.missing_moves, r.seq_out,
                             r.move_direction_out, r.stealth_out, r.z_bits_out);
        endfunction

        function void check_report(rcsf_pkg::t_out_item got);
            rcsf_pkg::t_out_item exp;
            bit                  bad;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output transaction: %s", $realtime, show(got));
                return;
            end
            exp = due_reports.pop_front();
            bad = (got.kind !== exp.kind) || (got.status !== exp.status) ||
                  (got.lost_packets !== exp.lost_packets) ||
                  (got.missing_moves !== exp.missing_moves) ||
                  (got.seq_out !== exp.seq_out) ||
                  (got.move_direction_out !== exp.move_direction_out) ||
                  (got.stealth_out !== exp.stealth_out) ||
                  (got.z_bits_out !== exp.z_bits_out);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch", $realtime);
                    $display("    expected: %s", show(exp));
                    $display("    actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [7:0]          cfg_data  = 8'd0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    rcsf_pkg::t_in_item  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    rcsf_pkg::t_out_item out_data;

    sequence_scoreboard sb = new();

    int         burst_left = 0;
    bit         quiet      = 1'b1;
    int         idle_cycles = 0;
    int         items_sent  = 0;
    logic [9:0] stall_phase = '0;
    int         stall_mode  = 0;
    logic [7:0] gen_seq;

    redundant_command_sequence_filter_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_report(out_data);
            if (in_valid && !in_stall)
                sb.record_item(in_data);
            if (cfg_we)
                sb.write_series(cfg_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("** redundant_command_sequence_filter_top: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(posedge clk) begin
        stall_phase <= stall_phase + 10'd1;
        if (stall_phase[6:0] == 7'd0)
            stall_mode <= $urandom_range(0, 3);
        if (quiet || !rst_n) begin
            out_stall <= 1'b0;
        end else begin
            case (stall_mode)
                1: begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    out_stall <= ($urandom_range(0, 9) < 7);
                end
                3: begin
                    out_stall <= (stall_phase[2:0] != 3'd0);
                end
                default: begin
                    out_stall <= 1'b0;
                end
            endcase
        end
    end

    function automatic rcsf_pkg::t_in_item random_item();
        rcsf_pkg::t_in_item it;
        logic [95:0]        raw;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(rcsf_pkg::t_in_item)-1:0];
        return it;
    endfunction

    function automatic rcsf_pkg::t_in_item header_item(logic [7:0] seq, logic [7:0] series,
                                                       logic [7:0] mm);
        rcsf_pkg::t_in_item it;
        it                 = random_item();
        it.cmd             = rcsf_pkg::CMD_HEADER;
        it.seq_num         = seq;
        it.series_num      = series;
        it.moves_minus_one = mm;
        return it;
    endfunction

    function automatic rcsf_pkg::t_in_item move_item(logic signed [7:0] dir,
                                                     logic [7:0] stealth,
                                                     logic [31:0] z);
        rcsf_pkg::t_in_item it;
        it                = random_item();
        it.cmd            = rcsf_pkg::CMD_MOVE;
        it.move_direction = dir;
        it.stealth        = stealth;
        it.z_bits         = z;
        return it;
    endfunction

    task automatic push_item(input rcsf_pkg::t_in_item it);
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (!quiet && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end else if (burst_left != 0) begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_series(input logic [7:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic push_random_moves(input int n);
        for (int i = 0; i < n; i++)
            push_item(move_item(8'($urandom), 8'($urandom), $urandom));
    endtask

    task automatic run_phase(input logic [7:0] series, input int target);
        rcsf_pkg::t_in_item it;
        int                 r;
        int                 delta;
        int                 n_moves;
        int                 count;
        logic [7:0]         mm;
        gen_seq = 8'($urandom);
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_item(random_item());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)      delta = $urandom_range(1, 3);
                else if (r < 80) delta = $urandom_range(4, 20);
                else if (r < 88) delta = 0;
                else if (r < 94) delta = $urandom_range(128, 255);
                else             delta = $urandom_range(21, 127);
                r = $urandom_range(0, 99);
                if (r < 75)      mm = 8'($urandom_range(0, 7));
                else if (r < 85) mm = 8'($urandom_range(8, 30));
                else if (r < 92) mm = 8'd255;
                else if (r < 97) mm = 8'($urandom_range(31, 80));
                else             mm = 8'($urandom_range(0, 254));
                it = header_item(gen_seq + delta[7:0],
                                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : series, mm);
                if (delta >= 1 && delta <= 127)
                    gen_seq = gen_seq + delta[7:0];
                count = (int'(mm) + 1) % 256;
                r = $urandom_range(0, 99);
                if (r < 85)      n_moves = count;
                else if (r < 93) n_moves = $urandom_range(0, count);
                else             n_moves = count + $urandom_range(1, 2);
                push_item(it);
                push_random_moves(n_moves);
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        quiet = 1'b1;
        push_item(move_item(-8'sd128, 8'hff, 32'hffff_ffff));
        push_item(header_item(8'd10, 8'd5, 8'd2));
        push_item(header_item(8'd10, 8'd0, 8'd2));
        push_item(move_item(8'sd127, 8'h00, 32'h0000_0000));
        push_item(move_item(-8'sd128, 8'hff, 32'hffff_ffff));
        push_item(move_item(8'sd0, 8'h5a, 32'h8000_0001));
        push_item(move_item(8'sd1, 8'h01, 32'h7fff_fffe));
        push_item(header_item(8'd10, 8'd0, 8'd2));
        push_item(move_item(-8'sd1, 8'h80, 32'h1234_5678));
        push_item(header_item(8'd12, 8'd0, 8'd3));
        push_random_moves(4);
        push_item(header_item(8'd212, 8'd0, 8'd0));
        push_item(header_item(8'd20, 8'd0, 8'd255));
        push_item(move_item(8'sd3, 8'h03, 32'h0000_0003));
        push_item(header_item(8'd147, 8'd0, 8'd0));
        push_item(move_item(8'sd127, 8'hff, 32'hffff_ffff));
        push_item(header_item(8'd148, 8'd0, 8'd4));
        push_item(move_item(8'sd2, 8'h02, 32'h0000_0002));
        push_item(header_item(8'd150, 8'd0, 8'd1));
        push_item(move_item(-8'sd2, 8'hfe, 32'hdead_beef));
        wait_drained();
        write_series(8'd0);
        push_item(move_item(8'sd4, 8'h04, 32'hcafe_f00d));
        push_item(header_item(8'd255, 8'd0, 8'd255));
        push_item(header_item(8'd255, 8'd0, 8'd0));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            quiet = (p == 3);
            write_series((p == 0) ? 8'hff : (p == 1) ? 8'h00 : 8'($urandom));
            run_phase(cfg_data, items_sent + RANDOM_ITEMS / PHASE_COUNT);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_reports.size() == 0) begin
            $display("** redundant_command_sequence_filter_top: PASSED **");
        end else begin
            $display("** redundant_command_sequence_filter_top: FAILED **");
        end
        $finish;
    end

endmodule
